/* rtl/ppd_pkg.sv */
// Package for the priority periodic task dispatcher.
// It holds the table entry type and the status codes. It has no dependencies.
`default_nettype none
package ppd_pkg;

  typedef struct packed {
    logic [7:0] prio;
    logic [7:0] period;
    logic [7:0] id;
  } entry_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_BAD_PERIOD = 3'd2;
  localparam logic [2:0] ST_EMPTY      = 3'd3;
  localparam logic [2:0] ST_NONE_DUE   = 3'd4;

endpackage
`default_nettype wire

/* rtl/priority_periodic_task_dispatcher.sv */
// Top level of the priority periodic task dispatcher: a row of table cells,
// a bit-serial remainder unit and the scan control. Depends on ppd_pkg, ppd_cell.
//
// Channel | Direction | Contents
// s_axis  | in        | tdata: task_priority, task_period, task_id; tuser: kind
// m_axis  | out       | tdata: status, due_task; tlast: last
//
// A create is answered from the idle state. A tick runs the remainder unit over every
// occupied table entry; the remainder unit shifts in one tick bit a cycle.
// Reset clears the count, the tick counter and the control; the table has none.
// A stalled output holds the scan until the result register frees.
`default_nettype none
module priority_periodic_task_dispatcher #(
  parameter int MAX_TASKS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // task_priority, task_period, task_id
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status, due_task, zero fill
  output logic        m_axis_tlast   // last
);
  import ppd_pkg::*;

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MOD   = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [15:0]   tick_q, tick_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [3:0]    bit_q, bit_d;
  logic [7:0]    rem_q, rem_d;
  logic          pend_v_q, pend_v_d;
  logic [7:0]    pend_id_q, pend_id_d;
  logic          out_v_q, out_v_d;
  logic [2:0]    out_st_q, out_st_d;
  logic [7:0]    out_id_q, out_id_d;
  logic          out_l_q, out_l_d;

  entry_t new_entry, cur;
  entry_t entries [MAX_TASKS];
  logic   keeps   [MAX_TASKS];
  logic   ins, in_fire, can_emit;
  logic [9:0] trial;

  assign new_entry = '{prio: s_axis_tdata[7:0], period: s_axis_tdata[15:8],
                       id: s_axis_tdata[23:16]};
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign can_emit  = !out_v_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && can_emit;
  assign ins = in_fire && !s_axis_tuser && (new_entry.period != 8'd0)
               && (count_q != CW'(MAX_TASKS));

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    ppd_cell u_cell (
      .clk_i      (clk_i),
      .ins_i      (ins),
      .occupied_i (CW'(g) < count_q),
      .new_i      (new_entry),
      .prev_i     ((g == 0) ? new_entry : entries[(g == 0) ? 0 : g - 1]),
      .prev_keep_i((g == 0) ? 1'b1 : keeps[(g == 0) ? 0 : g - 1]),
      .entry_o    (entries[g]),
      .keep_o     (keeps[g])
    );
  end

  assign cur   = entries[idx_q];
  assign trial = {1'b0, rem_q, tick_q[bit_q]} - {2'b0, cur.period};

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    tick_d    = tick_q;
    idx_d     = idx_q;
    bit_d     = bit_q;
    rem_d     = rem_q;
    pend_v_d  = pend_v_q;
    pend_id_d = pend_id_q;
    out_v_d   = out_v_q && !m_axis_tready;
    out_st_d  = out_st_q;
    out_id_d  = out_id_q;
    out_l_d   = out_l_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_v_d  = 1'b1;
          out_id_d = 8'd0;
          out_l_d  = 1'b1;
          if (!s_axis_tuser) begin
            if (new_entry.period == 8'd0) begin
              out_st_d = ST_BAD_PERIOD;
            end else if (count_q == CW'(MAX_TASKS)) begin
              out_st_d = ST_FULL;
            end else begin
              out_st_d = ST_OK;
              count_d  = count_q + CW'(1);
            end
          end else begin
            tick_d = tick_q + 16'd1;
            if (count_q == '0) begin
              out_st_d = ST_EMPTY;
            end else begin
              out_v_d  = out_v_q && !m_axis_tready;
              idx_d    = '0;
              bit_d    = 4'd15;
              rem_d    = 8'd0;
              pend_v_d = 1'b0;
              state_d  = S_MOD;
            end
          end
        end
      end
      S_MOD: begin
        rem_d = trial[9] ? {rem_q[6:0], tick_q[bit_q]} : trial[7:0];
        bit_d = bit_q - 4'd1;
        if (bit_q == 4'd0) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (rem_q != 8'd0 || !pend_v_q || can_emit) begin
          if (rem_q == 8'd0) begin
            if (pend_v_q) begin
              out_v_d  = 1'b1;
              out_st_d = ST_OK;
              out_id_d = pend_id_q;
              out_l_d  = 1'b0;
            end
            pend_v_d  = 1'b1;
            pend_id_d = cur.id;
          end
          if ({{(CW-IW){1'b0}}, idx_q} == count_q - CW'(1)) begin
            state_d = S_FLUSH;
          end else begin
            idx_d   = idx_q + IW'(1);
            bit_d   = 4'd15;
            rem_d   = 8'd0;
            state_d = S_MOD;
          end
        end
      end
      S_FLUSH: begin
        if (can_emit) begin
          out_v_d  = 1'b1;
          out_l_d  = 1'b1;
          out_st_d = pend_v_q ? ST_OK : ST_NONE_DUE;
          out_id_d = pend_v_q ? pend_id_q : 8'd0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      tick_q   <= 16'd0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      tick_q   <= tick_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    bit_q     <= bit_d;
    rem_q     <= rem_d;
    pend_id_q <= pend_id_d;
    out_st_q  <= out_st_d;
    out_id_q  <= out_id_d;
    out_l_q   <= out_l_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'd0, out_id_q, out_st_q};
  assign m_axis_tlast  = out_l_q;
endmodule
`default_nettype wire

/* rtl/ppd_cell.sv */
// One slot of the sorted task table. On an insert it keeps its entry,
// takes the new one or takes its left neighbour's. Depends on ppd_pkg.
`default_nettype none
module ppd_cell (
  input  logic           clk_i,
  input  logic           ins_i,
  input  logic           occupied_i,
  input  ppd_pkg::entry_t new_i,
  input  ppd_pkg::entry_t prev_i,
  input  logic           prev_keep_i,
  output ppd_pkg::entry_t entry_o,
  output logic           keep_o
);
  import ppd_pkg::*;

  entry_t entry_q, entry_d;

  assign keep_o = occupied_i && (entry_q.prio <= new_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ins_i && !keep_o) begin
      entry_d = prev_keep_i ? new_i : prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
endmodule
`default_nettype wire
